[src/frs_pkg.sv]
// ============================================================================
// frs_pkg
// Shared types, constants and helper functions for the Fenwick range-sum
// table: command codes, the queued command format and back-end states.
// ============================================================================
`default_nettype none

package frs_pkg;

    // Table geometry.
    localparam int SIZE   = 1024;
    localparam int ADDR_W = $clog2(SIZE);
    localparam int WALK_W = ADDR_W + 2;
    localparam int IDX_W  = 11;
    localparam int VAL_W  = 32;
    localparam int SUM_W  = 64;

    // Action codes on the input port.
    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

    // Classified operation carried through the queue.
    typedef enum logic [1:0] {
        OP_ADD,
        OP_SET,
        OP_QUERY,
        OP_BAD
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t                  op;
        logic [IDX_W-1:0]         index_a;
        logic [IDX_W-1:0]         index_b;
        logic signed [VAL_W-1:0]  value;
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK1,
        ST_WALK2,
        ST_DRAIN,
        ST_UPDATE
    } back_state_t;

    // Status from the back end to the rest of the block.
    typedef struct packed {
        logic clearing;
    } back_status_t;

    // A position is usable when it lies in 1..SIZE.
    function automatic logic pos_ok(input logic [IDX_W-1:0] k);
        return (k != '0) && (k <= IDX_W'(SIZE));
    endfunction

    // Lowest set bit of a walk index.
    function automatic logic [WALK_W-1:0] low_bit(input logic [WALK_W-1:0] k);
        return k & (~k + WALK_W'(1));
    endfunction

endpackage

`default_nettype wire

[src/fenwick_range_sum_table.sv]
// ============================================================================
// fenwick_range_sum_table
// Binary indexed tree over 1024 one-based positions with point add, point
// set and range-sum query; sums wrap at 64 bits.
// ============================================================================
//
//  Channel   Signals                                   Transaction
//  -------   ---------------------------------------   -------------------------
//  command   start, busy, action, index_a, index_b,    start high, busy low
//            value
//  result    done, range_sum, bad_index                done high for one cycle
//
//  An add runs one update walk in the back end, a query two prefix walks, a set
//  two prefix walks and then an update walk, and a flagged command no walk;
//  each walk visits at most 11 tree nodes. The tree store reads one node per
//  cycle and writes back through its own write port.
//  After reset the store is cleared; busy stays high meanwhile.
//  Two queued commands plus one held command absorb bursts; busy rises when
//  they are all taken. Results cannot be stalled.
//
`default_nettype none

module fenwick_range_sum_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    action,
    input  wire logic [frs_pkg::IDX_W-1:0]     index_a,
    input  wire logic [frs_pkg::IDX_W-1:0]     index_b,
    input  wire logic [frs_pkg::VAL_W-1:0]     value,
    output logic                               done,
    output logic [frs_pkg::SUM_W-1:0]          range_sum,
    output logic                               bad_index
);

    frs_pkg::back_status_t  status;
    frs_pkg::cmd_t          push_cmd;
    frs_pkg::cmd_t          head_cmd;
    logic                   push;
    logic                   q_full;
    logic                   pop;
    logic                   head_valid;

    // Front end: accept and classify.
    frs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .action   (action),
        .index_a  (index_a),
        .index_b  (index_b),
        .value    (value),
        .status   (status),
        .q_full   (q_full),
        .busy     (busy),
        .push     (push),
        .push_cmd (push_cmd)
    );

    // Command queue between the two halves.
    frs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    // Back end: walks over the tree store.
    frs_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .status     (status),
        .done       (done),
        .range_sum  (range_sum),
        .bad_index  (bad_index)
    );

    // No result while the store is still being cleared.
    assert property (@(posedge clk) disable iff (!rst_n) status.clearing |-> !done)
        else $error("result during clearing sweep");

    // Commands are refused while clearing.
    assert property (@(posedge clk) disable iff (!rst_n) status.clearing |-> busy)
        else $error("not busy during clearing sweep");

    // A flagged result carries a zero sum.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (done && bad_index) |-> (range_sum == '0))
        else $error("bad index result with nonzero sum");

    // The back end only takes a command that is there.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

[src/frs_front.sv]
// ============================================================================
// frs_front
// Accepts input transactions, checks their positions, classifies them and
// hands them to the command queue through a one-entry holding register.
// ============================================================================
`default_nettype none

module frs_front (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [1:0]                   action,
    input  wire logic [frs_pkg::IDX_W-1:0]    index_a,
    input  wire logic [frs_pkg::IDX_W-1:0]    index_b,
    input  wire logic [frs_pkg::VAL_W-1:0]    value,
    input  wire frs_pkg::back_status_t        status,
    input  wire logic                         q_full,
    output logic                              busy,
    output logic                              push,
    output frs_pkg::cmd_t                     push_cmd
);

    logic           hold_valid_reg;
    logic           hold_valid_next;
    frs_pkg::cmd_t  hold_cmd_reg;
    frs_pkg::cmd_t  hold_cmd_next;
    logic           accept;
    logic           keep;

    // Stall while the store is being cleared or the holding register is stuck.
    assign busy     = status.clearing || (hold_valid_reg && q_full);
    assign accept   = start && !busy;
    assign push     = hold_valid_reg && !q_full;
    assign push_cmd = hold_cmd_reg;

    // Classify the incoming transaction.
    always_comb
    begin
        hold_cmd_next         = hold_cmd_reg;
        keep                  = 1'b1;
        hold_cmd_next.index_a = index_a;
        hold_cmd_next.index_b = index_b;
        hold_cmd_next.value   = value;
        unique case (action) inside
            frs_pkg::ACT_ADD, frs_pkg::ACT_SET:
            begin
                if (!frs_pkg::pos_ok(index_a))
                    hold_cmd_next.op = frs_pkg::OP_BAD;
                else if (action == frs_pkg::ACT_ADD)
                    hold_cmd_next.op = frs_pkg::OP_ADD;
                else
                    hold_cmd_next.op = frs_pkg::OP_SET;
            end
            frs_pkg::ACT_QUERY:
            begin
                if (frs_pkg::pos_ok(index_a) && frs_pkg::pos_ok(index_b))
                    hold_cmd_next.op = frs_pkg::OP_QUERY;
                else
                    hold_cmd_next.op = frs_pkg::OP_BAD;
            end
            default:
            begin
                // The unused action code is dropped here.
                keep = 1'b0;
            end
        endcase
    end

    // Holding register occupancy.
    always_comb
    begin
        if (accept)
            hold_valid_next = keep;
        else if (push)
            hold_valid_next = 1'b0;
        else
            hold_valid_next = hold_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_valid_reg <= 1'b0;
        else
            hold_valid_reg <= hold_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            hold_cmd_reg <= hold_cmd_next;
    end

endmodule

`default_nettype wire

[src/frs_queue.sv]
// ============================================================================
// frs_queue
// Two-entry command queue that decouples the front end from the back end.
// ============================================================================
`default_nettype none

module frs_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire frs_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               head_valid,
    output frs_pkg::cmd_t      head_cmd
);

    frs_pkg::cmd_t  entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_pop;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = entry_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

`default_nettype wire

[src/frs_back.sv]
// ============================================================================
// frs_back
// Executes queued commands against the tree store: prefix walks for queries
// and point sets, a read-modify-write walk for updates, and the clearing
// sweep after reset.
// ============================================================================
`default_nettype none

module frs_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          head_valid,
    input  wire frs_pkg::cmd_t                 head_cmd,
    output logic                               pop,
    output frs_pkg::back_status_t              status,
    output logic                               done,
    output logic [frs_pkg::SUM_W-1:0]          range_sum,
    output logic                               bad_index
);

    localparam int AW = frs_pkg::ADDR_W;
    localparam int KW = frs_pkg::WALK_W;
    localparam int SW = frs_pkg::SUM_W;

    logic [SW-1:0]          tree_mem [frs_pkg::SIZE];

    frs_pkg::back_state_t   state_reg;
    frs_pkg::back_state_t   state_next;
    frs_pkg::cmd_t          cmd_reg;
    frs_pkg::cmd_t          cmd_next;
    logic [KW-1:0]          k_reg;
    logic [KW-1:0]          k_next;
    logic [SW-1:0]          acc_reg;
    logic [SW-1:0]          acc_next;
    logic [SW-1:0]          acc_after;
    logic                   acc_pend_reg;
    logic                   acc_pend_next;
    logic                   acc_sub_reg;
    logic                   acc_sub_next;
    logic                   rmw_pend_reg;
    logic                   rmw_pend_next;
    logic [AW-1:0]          wr_addr_reg;
    logic [AW-1:0]          wr_addr_next;
    logic [AW-1:0]          clr_cnt_reg;
    logic [AW-1:0]          clr_cnt_next;
    logic [SW-1:0]          rdata_reg;
    logic                   done_reg;
    logic                   done_next;
    logic [SW-1:0]          range_sum_reg;
    logic [SW-1:0]          range_sum_next;
    logic                   bad_index_reg;
    logic                   bad_index_next;

    logic                   mem_rd_en;
    logic [AW-1:0]          mem_rd_addr;
    logic                   mem_wr_en;
    logic [AW-1:0]          mem_wr_addr;
    logic [SW-1:0]          mem_wr_data;
    logic [KW-1:0]          k_top;

    assign k_top              = KW'(frs_pkg::SIZE);
    assign status.clearing    = (state_reg == frs_pkg::ST_CLEAR);
    assign done               = done_reg;
    assign range_sum          = range_sum_reg;
    assign bad_index          = bad_index_reg;

    // Accumulate the read that was issued last cycle, with its sign.
    always_comb
    begin
        if (acc_pend_reg)
            acc_after = acc_sub_reg ? (acc_reg - rdata_reg) : (acc_reg + rdata_reg);
        else
            acc_after = acc_reg;
    end

    // Next-state logic of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            frs_pkg::ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(frs_pkg::SIZE - 1))
                    state_next = frs_pkg::ST_IDLE;
            end
            frs_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    unique case (head_cmd.op)
                        frs_pkg::OP_ADD:   state_next = frs_pkg::ST_UPDATE;
                        frs_pkg::OP_SET:   state_next = frs_pkg::ST_WALK1;
                        frs_pkg::OP_QUERY: state_next = frs_pkg::ST_WALK1;
                        default:           state_next = frs_pkg::ST_IDLE;
                    endcase
                end
            end
            frs_pkg::ST_WALK1:
            begin
                if (k_reg == '0)
                    state_next = frs_pkg::ST_WALK2;
            end
            frs_pkg::ST_WALK2:
            begin
                if (k_reg == '0)
                    state_next = frs_pkg::ST_DRAIN;
            end
            frs_pkg::ST_DRAIN:
            begin
                if (!acc_pend_reg)
                    state_next = (cmd_reg.op == frs_pkg::OP_SET) ? frs_pkg::ST_UPDATE
                                                                 : frs_pkg::ST_IDLE;
            end
            frs_pkg::ST_UPDATE:
            begin
                if ((k_reg > k_top) && !rmw_pend_reg)
                    state_next = frs_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = frs_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control and outputs of the sequencer.
    always_comb
    begin
        pop            = 1'b0;
        cmd_next       = cmd_reg;
        k_next         = k_reg;
        acc_next       = acc_after;
        acc_pend_next  = 1'b0;
        acc_sub_next   = acc_sub_reg;
        rmw_pend_next  = 1'b0;
        wr_addr_next   = wr_addr_reg;
        clr_cnt_next   = clr_cnt_reg;
        done_next      = 1'b0;
        range_sum_next = range_sum_reg;
        bad_index_next = bad_index_reg;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = AW'(k_reg - KW'(1));
        mem_wr_en      = 1'b0;
        mem_wr_addr    = wr_addr_reg;
        mem_wr_data    = rdata_reg + acc_reg;

        // Write back the node read in the previous update step.
        if (rmw_pend_reg)
            mem_wr_en = 1'b1;

        unique case (state_reg)
            frs_pkg::ST_CLEAR:
            begin
                mem_wr_en    = 1'b1;
                mem_wr_addr  = clr_cnt_reg;
                mem_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
            end
            frs_pkg::ST_IDLE:
            begin
                if (head_valid)
                begin
                    pop      = 1'b1;
                    cmd_next = head_cmd;
                    if (head_cmd.op == frs_pkg::OP_QUERY)
                    begin
                        acc_next = '0;
                        k_next   = KW'(head_cmd.index_b);
                    end
                    else
                    begin
                        acc_next = {{(SW - frs_pkg::VAL_W){head_cmd.value[frs_pkg::VAL_W-1]}},
                                    head_cmd.value};
                        k_next   = KW'(head_cmd.index_a);
                    end
                    if (head_cmd.op == frs_pkg::OP_BAD)
                    begin
                        done_next      = 1'b1;
                        range_sum_next = '0;
                        bad_index_next = 1'b1;
                    end
                end
            end
            frs_pkg::ST_WALK1, frs_pkg::ST_WALK2:
            begin
                if (k_reg != '0)
                begin
                    mem_rd_en     = 1'b1;
                    acc_pend_next = 1'b1;
                    k_next        = k_reg - frs_pkg::low_bit(k_reg);
                    // A query adds prefix(b) and subtracts prefix(a-1); a set
                    // subtracts prefix(a) and adds prefix(a-1).
                    if (state_reg == frs_pkg::ST_WALK1)
                        acc_sub_next = (cmd_reg.op == frs_pkg::OP_SET);
                    else
                        acc_sub_next = (cmd_reg.op == frs_pkg::OP_QUERY);
                end
                else if (state_reg == frs_pkg::ST_WALK1)
                begin
                    k_next = KW'(cmd_reg.index_a) - KW'(1);
                end
            end
            frs_pkg::ST_DRAIN:
            begin
                if (!acc_pend_reg)
                begin
                    if (cmd_reg.op == frs_pkg::OP_SET)
                    begin
                        k_next = KW'(cmd_reg.index_a);
                    end
                    else
                    begin
                        done_next      = 1'b1;
                        range_sum_next = acc_reg;
                        bad_index_next = 1'b0;
                    end
                end
            end
            frs_pkg::ST_UPDATE:
            begin
                if (k_reg <= k_top)
                begin
                    mem_rd_en     = 1'b1;
                    rmw_pend_next = 1'b1;
                    wr_addr_next  = AW'(k_reg - KW'(1));
                    k_next        = k_reg + frs_pkg::low_bit(k_reg);
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= frs_pkg::ST_CLEAR;
            clr_cnt_reg  <= '0;
            acc_pend_reg <= 1'b0;
            rmw_pend_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            acc_pend_reg <= acc_pend_next;
            rmw_pend_reg <= rmw_pend_next;
            done_reg     <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        k_reg         <= k_next;
        acc_reg       <= acc_next;
        acc_sub_reg   <= acc_sub_next;
        wr_addr_reg   <= wr_addr_next;
        range_sum_reg <= range_sum_next;
        bad_index_reg <= bad_index_next;
    end

    // Tree store: one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            tree_mem[mem_wr_addr] <= mem_wr_data;
        if (mem_rd_en)
            rdata_reg <= tree_mem[mem_rd_addr];
    end

endmodule

`default_nettype wire

[verif/fenwick_range_sum_checker.sv]
// ============================================================================
// fenwick_range_sum_checker
// Watches the command and result channels of the Fenwick range-sum table. It
// keeps a flat copy of every position's value, works out the sum or the bad
// position flag that each accepted command should produce, and compares each
// result strobe against the oldest outstanding expectation.
// ============================================================================

module fenwick_range_sum_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [1:0]                   action,
    input  logic [frs_pkg::IDX_W-1:0]    index_a,
    input  logic [frs_pkg::IDX_W-1:0]    index_b,
    input  logic [frs_pkg::VAL_W-1:0]    value,
    input  logic                         done,
    input  logic [frs_pkg::SUM_W-1:0]    range_sum,
    input  logic                         bad_index,
    output int                           error_count,
    output int                           results_pending,
    output int                           results_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_W      = frs_pkg::SUM_W;
    localparam int VAL_W      = frs_pkg::VAL_W;
    localparam int IDX_W      = frs_pkg::IDX_W;
    localparam int FIFO_DEPTH = 16;

    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic             bad;
    } sum_result_t;

    // Plain value held at each one-based position; the tree is not modeled.
    logic [SUM_W-1:0] position_value [1:frs_pkg::SIZE];
    // Ring of outstanding expectations, oldest at exp_rd_count.
    sum_result_t      expected_sums [FIFO_DEPTH];
    int               exp_wr_count;
    int               exp_rd_count;
    int               mismatches;
    int               checked;

    initial
    begin
        mismatches   = 0;
        checked      = 0;
        exp_wr_count = 0;
        exp_rd_count = 0;
    end

    function automatic logic position_valid(input logic [IDX_W-1:0] k);
        return (k >= 1) && (k <= frs_pkg::SIZE);
    endfunction

    // Sum of positions 1..last, wrapping at 64 bits; zero for last = 0.
    function automatic logic [SUM_W-1:0] sum_through(input int last);
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int k = 1; k <= last; k++)
            acc += position_value[k];
        return acc;
    endfunction

    // Append one expectation to the ring.
    function automatic void expect_result(input logic [SUM_W-1:0] sum, input logic bad);
        if (exp_wr_count - exp_rd_count >= FIFO_DEPTH)
        begin
            mismatches++;
            $display("%0t: too many outstanding results", $time);
        end
        else
        begin
            expected_sums[exp_wr_count % FIFO_DEPTH] = '{sum: sum, bad: bad};
            exp_wr_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        sum_result_t      want;
        logic [SUM_W-1:0] widened;
        if (!rst_n)
        begin
            foreach (position_value[k])
                position_value[k] = '0;
            exp_wr_count = 0;
            exp_rd_count = 0;
        end
        else
        begin
            // Result transaction: compare with the oldest expectation first.
            if (done)
            begin
                if (exp_wr_count == exp_rd_count)
                begin
                    mismatches++;
                    $display("%0t: unexpected result, actual range_sum=%0d bad_index=%0b",
                             $time, $signed(range_sum), bad_index);
                end
                else
                begin
                    want = expected_sums[exp_rd_count % FIFO_DEPTH];
                    exp_rd_count++;
                    checked++;
                    if (range_sum !== want.sum)
                    begin
                        mismatches++;
                        $display("%0t: range_sum mismatch, expected %0d, actual %0d",
                                 $time, $signed(want.sum), $signed(range_sum));
                    end
                    if (bad_index !== want.bad)
                    begin
                        mismatches++;
                        $display("%0t: bad_index mismatch, expected %0b, actual %0b",
                                 $time, want.bad, bad_index);
                    end
                end
            end

            // Command transaction: update the positions or queue the answer.
            if (start && !busy)
            begin
                widened = {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
                case (action)
                    frs_pkg::ACT_QUERY:
                    begin
                        if (!position_valid(index_a) || !position_valid(index_b))
                            expect_result('0, 1'b1);
                        else
                            expect_result(sum_through(int'(index_b))
                                          - sum_through(int'(index_a) - 1), 1'b0);
                    end
                    frs_pkg::ACT_ADD, frs_pkg::ACT_SET:
                    begin
                        if (!position_valid(index_a))
                            expect_result('0, 1'b1);
                        else if (action == frs_pkg::ACT_ADD)
                            position_value[index_a] += widened;
                        else
                            position_value[index_a] = widened;
                    end
                    default:
                    begin
                        // The unused action code changes nothing.
                    end
                endcase
            end
        end
        error_count     <= mismatches;
        results_pending <= exp_wr_count - exp_rd_count;
        results_checked <= checked;
    end

endmodule

[verif/tb_fenwick_range_sum_table.sv]
// ============================================================================
// tb_fenwick_range_sum_table
// Drives directed and random add, set and range-query commands, including bad
// positions, reversed ranges and the unused action code, with random sender
// gaps, into the Fenwick range-sum table; the checker scores every result.
// ============================================================================

module tb_fenwick_range_sum_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int         IDX_W          = frs_pkg::IDX_W;
    localparam int         VAL_W          = frs_pkg::VAL_W;
    localparam int         SUM_W          = frs_pkg::SUM_W;
    localparam int         SIZE           = frs_pkg::SIZE;
    localparam logic [1:0] ACT_UNUSED     = 2'd3;
    localparam int         RANDOM_ITEMS   = 1700;
    localparam int         WATCHDOG_LIMIT = 5000;
    localparam int         DRAIN_CYCLES   = 200;

    localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(SIZE);
    localparam logic [IDX_W-1:0] POS_OVER = IDX_W'(SIZE + 1);

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [1:0]        action;
    logic [IDX_W-1:0]  index_a;
    logic [IDX_W-1:0]  index_b;
    logic [VAL_W-1:0]  value;
    logic              done;
    logic [SUM_W-1:0]  range_sum;
    logic              bad_index;

    int error_count;
    int results_pending;
    int results_checked;
    int stall_pct;
    int idle_cycles;
    int adds_sent;
    int sets_sent;
    int queries_sent;
    int bad_sent;
    int unused_sent;

    fenwick_range_sum_table DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .action    (action),
        .index_a   (index_a),
        .index_b   (index_b),
        .value     (value),
        .done      (done),
        .range_sum (range_sum),
        .bad_index (bad_index)
    );

    fenwick_range_sum_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .action          (action),
        .index_a         (index_a),
        .index_b         (index_b),
        .value           (value),
        .done            (done),
        .range_sum       (range_sum),
        .bad_index       (bad_index),
        .error_count     (error_count),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: ends the run when no transaction of either kind occurs for too long.
    initial
    begin
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    function automatic logic good_position(input logic [IDX_W-1:0] k);
        return (k >= 1) && (k <= SIZE);
    endfunction

    // Positions lean on the ends and on a few hot spots so sets see prior adds.
    function automatic logic [IDX_W-1:0] pick_position();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return ($urandom_range(0, 1) != 0) ? IDX_W'(1) : POS_LAST;
        else if (r < 22)
            return IDX_W'($urandom_range(1, 8));
        else if (r < 30)
            return IDX_W'($urandom_range(SIZE - 7, SIZE));
        else if (r < 96)
            return IDX_W'($urandom_range(1, SIZE));
        else if (r < 98)
            return '0;
        else
            return IDX_W'($urandom_range(SIZE + 1, (1 << IDX_W) - 1));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            4:       return VAL_W'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    // One command transaction; returns at the edge where it is taken, then
    // maybe holds start low for a random gap.
    task automatic issue_command(input logic [1:0] op, input logic [IDX_W-1:0] a,
                                 input logic [IDX_W-1:0] b, input logic [VAL_W-1:0] v);
        start   <= 1'b1;
        action  <= op;
        index_a <= a;
        index_b <= b;
        value   <= v;
        do
            @(posedge clk);
        while (busy);
        case (op)
            frs_pkg::ACT_ADD:   adds_sent++;
            frs_pkg::ACT_SET:   sets_sent++;
            frs_pkg::ACT_QUERY: queries_sent++;
            default:            unused_sent++;
        endcase
        if (op != ACT_UNUSED
            && (!good_position(a) || (op == frs_pkg::ACT_QUERY && !good_position(b))))
            bad_sent++;
        if ($urandom_range(0, 99) < stall_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    initial
    begin
        logic [1:0]       op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] swap;
        int               counted;
        int               r;

        rst_n   = 1'b0;
        start   = 1'b0;
        action  = frs_pkg::ACT_ADD;
        index_a = '0;
        index_b = '0;
        value   = '0;
        adds_sent    = 0;
        sets_sent    = 0;
        queries_sent = 0;
        bad_sent     = 0;
        unused_sent  = 0;
        stall_pct    = 26;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty table, extreme values and positions, set over
        // prior adds, reversed ranges, bad positions and the unused code.
        issue_command(frs_pkg::ACT_QUERY, 1, POS_LAST, 0);
        issue_command(frs_pkg::ACT_ADD, 1, 0, 32'h7FFF_FFFF);
        issue_command(frs_pkg::ACT_ADD, POS_LAST, 0, 32'h8000_0000);
        issue_command(frs_pkg::ACT_ADD, 512, 0, '1);
        issue_command(frs_pkg::ACT_ADD, 1, 0, 32'h7FFF_FFFF);
        issue_command(frs_pkg::ACT_QUERY, 1, POS_LAST, 0);
        issue_command(frs_pkg::ACT_SET, 1, 0, 5);
        issue_command(frs_pkg::ACT_SET, POS_LAST, 0, 32'h7FFF_FFFF);
        issue_command(frs_pkg::ACT_SET, 700, 0, 32'hFFFF_FF85);
        issue_command(frs_pkg::ACT_QUERY, 1, 1, 0);
        issue_command(frs_pkg::ACT_QUERY, POS_LAST, POS_LAST, 0);
        issue_command(frs_pkg::ACT_QUERY, 1, 512, 0);
        issue_command(frs_pkg::ACT_QUERY, 1000, 3, 0);
        issue_command(frs_pkg::ACT_QUERY, POS_LAST, 1, 0);
        issue_command(frs_pkg::ACT_ADD, 0, 0, 32'h1234_5678);
        issue_command(frs_pkg::ACT_SET, POS_OVER, 0, 32'h8000_0000);
        issue_command(frs_pkg::ACT_ADD, 11'h7FF, 11'h7FF, '1);
        issue_command(frs_pkg::ACT_QUERY, 0, 5, 0);
        issue_command(frs_pkg::ACT_QUERY, 5, POS_OVER, 0);
        issue_command(frs_pkg::ACT_QUERY, 11'h7FF, 11'h7FF, 0);
        issue_command(frs_pkg::ACT_QUERY, 5, 0, 0);
        issue_command(ACT_UNUSED, 3, 9, 32'hDEAD_BEEF);
        issue_command(ACT_UNUSED, 11'h7FF, 0, '1);
        issue_command(frs_pkg::ACT_QUERY, 1, POS_LAST, 0);

        // Random part: mostly well-formed commands over a growing table.
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            stall_pct = (counted < RANDOM_ITEMS / 3) ? 26 :
                        (counted < 2 * RANDOM_ITEMS / 3) ? 52 : 0;
            r = $urandom_range(0, 99);
            if (r < 36)
                op = frs_pkg::ACT_ADD;
            else if (r < 60)
                op = frs_pkg::ACT_SET;
            else if (r < 97)
                op = frs_pkg::ACT_QUERY;
            else
                op = ACT_UNUSED;
            a = pick_position();
            b = pick_position();
            if (op == frs_pkg::ACT_QUERY && good_position(a) && good_position(b))
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    a = 1;
                    b = POS_LAST;
                end
                else if (r < 75 && a > b)
                begin
                    swap = a;
                    a    = b;
                    b    = swap;
                end
            end
            issue_command(op, a, b, pick_value());
            if (op != ACT_UNUSED)
                counted++;
        end
        start <= 1'b0;

        // Let every outstanding result arrive, then a margin for stragglers.
        do
            @(posedge clk);
        while (results_pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d adds, %0d sets, %0d queries; %0d with bad positions, %0d unused codes.",
                 adds_sent, sets_sent, queries_sent, bad_sent, unused_sent);
        $display("Checked %0d results with sender gaps of 26, 52 and 0 percent.",
                 results_checked);
        if (results_pending != 0)
            $display("%0t: %0d expected results never arrived", $time, results_pending);
        if (error_count == 0 && results_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
